/* sv/tgr_pkg.sv */
package tgr_pkg;

  localparam int MaxPointsDefault = 5;

  localparam logic [15:0] TapMaxReset     = 16'd250;
  localparam logic [11:0] MoveLimitReset  = 12'd20;
  localparam logic [15:0] DoubleTapReset  = 16'd400;
  localparam logic [15:0] LongPressReset  = 16'd800;
  localparam logic [11:0] SwipeMinReset   = 12'd30;
  localparam logic [15:0] SwipeMaxReset   = 16'd500;

  localparam logic [2:0] RegTapMax    = 3'd0;
  localparam logic [2:0] RegMoveLimit = 3'd1;
  localparam logic [2:0] RegDoubleTap = 3'd2;
  localparam logic [2:0] RegLongPress = 3'd3;
  localparam logic [2:0] RegSwipeMin  = 3'd4;
  localparam logic [2:0] RegSwipeMax  = 3'd5;

  localparam logic [3:0] GestNone   = 4'd0;
  localparam logic [3:0] GestTap    = 4'd1;
  localparam logic [3:0] GestDouble = 4'd2;
  localparam logic [3:0] GestRight  = 4'd3;
  localparam logic [3:0] GestLeft   = 4'd4;
  localparam logic [3:0] GestDown   = 4'd5;
  localparam logic [3:0] GestUp     = 4'd6;
  localparam logic [3:0] GestTwo    = 4'd7;
  localparam logic [3:0] GestMulti  = 4'd8;
  localparam logic [3:0] GestLong   = 4'd9;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [2:0]  active_count;
    logic [11:0] pt_x;
    logic [11:0] pt_y;
    logic [11:0] begin_x;
    logic [11:0] begin_y;
    logic [31:0] touch_begin_ms;
    logic [31:0] touch_finish_ms;
    logic        pt_active;
    logic        pt_was_active;
    logic        last_point;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  gesture;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [2:0]  fingers;
    logic [31:0] stamp_ms;
    logic [31:0] amount;
  } out_item_t;

  typedef struct packed {
    logic [15:0] tap_max_ms;
    logic [11:0] move_limit;
    logic [15:0] double_tap_ms;
    logic [15:0] long_press_ms;
    logic [11:0] swipe_min_dist;
    logic [15:0] swipe_max_ms;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic take_point;
    logic start_close;
    logic start_iter;
    logic step_iter;
    logic finish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_last;
    logic iter_done;
  } sts_t;

endpackage

/* sv/tgr_ctrl.sv */
module tgr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  tgr_pkg::sts_t   sts,
  output tgr_pkg::cmd_t   cmd
);
  import tgr_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CALC, S_ITER, S_FIN, S_OUT} state_t;
  state_t state;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.take_point  = (state == S_IDLE) && in_valid;
    cmd.start_close = (state == S_CALC);
    cmd.start_iter  = (state == S_CALC);
    cmd.step_iter   = (state == S_ITER);
    // The frame is committed only once the result register can take it.
    cmd.finish      = (state == S_FIN) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_valid && !out_stall) out_valid <= 1'b0;
          if (in_valid && sts.is_last) state <= S_CALC;
        end
        S_CALC: begin
          if (out_valid && !out_stall) out_valid <= 1'b0;
          state <= S_ITER;
        end
        S_ITER: begin
          if (out_valid && !out_stall) out_valid <= 1'b0;
          if (sts.iter_done) state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* sv/tgr_dp.sv */
module tgr_dp #(
  parameter int MAX_POINTS = tgr_pkg::MaxPointsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  tgr_pkg::in_item_t   in_data,
  input  tgr_pkg::cfg_t       cfg,
  input  tgr_pkg::cmd_t       cmd,
  input  logic                out_hold,
  output tgr_pkg::sts_t       sts,
  output tgr_pkg::out_item_t  out_data
);
  import tgr_pkg::*;

  localparam int IdxW = $clog2(MAX_POINTS + 1);

  logic [IdxW-1:0] point_index;
  logic [2:0]  prev_count;
  logic [31:0] tap_time, long_press_start;
  logic [11:0] tap_x, tap_y;
  logic [15:0] sum_x, sum_y;
  logic [11:0] f_x, f_y, f_bx, f_by, s_x, s_y;
  logic [31:0] f_beg, f_fin;
  logic        f_act, f_was;
  logic [31:0] now;
  logic [2:0]  cnt;

  // Close-time registered intermediates.
  logic signed [12:0] dx, dy;
  logic [31:0] d2, ml2, sm2;
  // Shared iterative unit: integer square root (16 steps) and two
  // restoring dividers by prev_count (16 steps) run in lockstep.
  logic [4:0]  it;
  logic [31:0] sq_v, sq_r, sq_bit;
  logic [15:0] qx, qy, rx, ry;

  assign sts.is_last = in_data.last_point;
  assign sts.iter_done = (it == 5'd16);

  always_ff @(posedge clk) begin
    if (rst) begin
      point_index <= '0;
      prev_count <= '0;
      tap_time <= '0;
      tap_x <= '0;
      tap_y <= '0;
      long_press_start <= '0;
      sum_x <= '0;
      sum_y <= '0;
    end else begin
      if (cmd.take_point) begin
        if (point_index < IdxW'(MAX_POINTS)) begin
          if (point_index == '0) begin
            f_x <= in_data.pt_x;
            f_y <= in_data.pt_y;
            f_bx <= in_data.begin_x;
            f_by <= in_data.begin_y;
            f_beg <= in_data.touch_begin_ms;
            f_fin <= in_data.touch_finish_ms;
            f_act <= in_data.pt_active;
            f_was <= in_data.pt_was_active;
          end else if (point_index == IdxW'(1)) begin
            s_x <= in_data.pt_x;
            s_y <= in_data.pt_y;
          end
          if (32'(point_index) < 32'(prev_count)) begin
            sum_x <= sum_x + 16'(in_data.pt_x);
            sum_y <= sum_y + 16'(in_data.pt_y);
          end
          point_index <= point_index + IdxW'(1);
        end
        now <= in_data.now_ms;
        cnt <= in_data.active_count;
      end
      if (cmd.finish) begin
        if (prev_count != 3'd0 && cnt == 3'd0 && prev_count == 3'd1 && f_was &&
            d2 <= ml2 && (f_fin - f_beg) <= 32'(cfg.tap_max_ms)) begin
          if ((now - tap_time) < 32'(cfg.double_tap_ms) &&
              ((f_x > tap_x) ? f_x - tap_x : tap_x - f_x) < cfg.move_limit &&
              ((f_y > tap_y) ? f_y - tap_y : tap_y - f_y) < cfg.move_limit) begin
            tap_time <= '0;
          end else begin
            tap_time <= now;
            tap_x <= f_x;
            tap_y <= f_y;
          end
        end
        if (cnt == 3'd1 && prev_count == 3'd1 && f_act &&
            (now - f_beg) > 32'(cfg.long_press_ms) && d2 <= ml2 &&
            f_beg != long_press_start) begin
          long_press_start <= f_beg;
        end
        prev_count <= cnt;
        point_index <= '0;
        sum_x <= '0;
        sum_y <= '0;
      end
    end
  end

  logic signed [12:0] dx_c, dy_c;
  assign dx_c = $signed({1'b0, f_x}) - $signed({1'b0, f_bx});
  assign dy_c = $signed({1'b0, f_y}) - $signed({1'b0, f_by});

  logic [31:0] sq_try;
  logic [16:0] rx_sh, ry_sh;
  assign sq_try = sq_r + sq_bit;
  assign rx_sh = {rx, qx[15]};
  assign ry_sh = {ry, qy[15]};

  always_ff @(posedge clk) begin
    if (cmd.start_close) begin
      dx <= dx_c;
      dy <= dy_c;
      d2 <= 32'(dx_c * dx_c) + 32'(dy_c * dy_c);
      ml2 <= 32'(cfg.move_limit * cfg.move_limit);
      sm2 <= 32'(cfg.swipe_min_dist * cfg.swipe_min_dist);
    end
    if (rst) begin
      it <= '0;
    end else if (cmd.start_iter) begin
      it <= '0;
      sq_v <= 32'(dx_c * dx_c) + 32'(dy_c * dy_c);
      sq_r <= '0;
      sq_bit <= 32'h4000_0000;
      qx <= sum_x;
      qy <= sum_y;
      rx <= '0;
      ry <= '0;
    end else if (cmd.step_iter && it != 5'd16) begin
      it <= it + 5'd1;
      if (sq_v >= sq_try) begin
        sq_v <= sq_v - sq_try;
        sq_r <= (sq_r >> 1) + sq_bit;
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
      if (rx_sh >= 17'(prev_count)) begin
        rx <= 16'(rx_sh - 17'(prev_count));
        qx <= {qx[14:0], 1'b1};
      end else begin
        rx <= rx_sh[15:0];
        qx <= {qx[14:0], 1'b0};
      end
      if (ry_sh >= 17'(prev_count)) begin
        ry <= 16'(ry_sh - 17'(prev_count));
        qy <= {qy[14:0], 1'b1};
      end else begin
        ry <= ry_sh[15:0];
        qy <= {qy[14:0], 1'b0};
      end
    end
  end

  out_item_t res;
  logic [31:0] dur_t, dur_l;
  logic [12:0] ax, ay;
  logic [12:0] mx, my;
  always_comb begin
    res = '0;
    res.fingers = cnt;
    res.stamp_ms = now;
    dur_t = f_fin - f_beg;
    dur_l = now - f_beg;
    ax = dx[12] ? 13'(-dx) : 13'(dx);
    ay = dy[12] ? 13'(-dy) : 13'(dy);
    mx = 13'(f_x) + 13'(s_x);
    my = 13'(f_y) + 13'(s_y);
    if (prev_count != 3'd0 && cnt == 3'd0) begin
      if (prev_count == 3'd1) begin
        res.fingers = 3'd1;
        res.pos_x = f_x;
        res.pos_y = f_y;
        if (f_was) begin
          if (d2 <= ml2 && dur_t <= 32'(cfg.tap_max_ms)) begin
            if ((now - tap_time) < 32'(cfg.double_tap_ms) &&
                ((f_x > tap_x) ? f_x - tap_x : tap_x - f_x) < cfg.move_limit &&
                ((f_y > tap_y) ? f_y - tap_y : tap_y - f_y) < cfg.move_limit) begin
              res.gesture = GestDouble;
              res.amount = 32'd2;
            end else begin
              res.gesture = GestTap;
              res.amount = 32'd1;
            end
          end else if (d2 > sm2 && dur_t < 32'(cfg.swipe_max_ms)) begin
            if (ax > ay) res.gesture = (!dx[12] && dx != '0) ? GestRight : GestLeft;
            else res.gesture = (!dy[12] && dy != '0) ? GestDown : GestUp;
            res.amount = sq_r;
          end
        end
      end else if (prev_count == 3'd2) begin
        res.gesture = GestTwo;
        res.fingers = 3'd2;
        res.amount = 32'd2;
        res.pos_x = mx[12:1];
        res.pos_y = my[12:1];
      end else begin
        res.gesture = GestMulti;
        res.fingers = prev_count;
        res.amount = 32'(prev_count);
        res.pos_x = qx[11:0];
        res.pos_y = qy[11:0];
      end
    end
    if (cnt == 3'd1 && prev_count == 3'd1 && f_act && dur_l > 32'(cfg.long_press_ms) &&
        d2 <= ml2 && f_beg != long_press_start) begin
      res.gesture = GestLong;
      res.pos_x = f_x;
      res.pos_y = f_y;
      res.amount = dur_l;
      res.fingers = 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && !out_hold) out_data <= res;
  end
endmodule

/* sv/touch_gesture_recognizer_core.sv */
// A frame's closing request runs through S_CALC, S_ITER and S_FIN before its result is
// registered, and S_FIN waits while an earlier result still waits on out_stall.
// Point requests are taken one per cycle while in_stall is low; a closing request holds input
// until its result is registered, through the 16-step shared square root and centroid divider.
// Reset (rst, synchronous, active high) restores register defaults and clears all
// gesture state; the stored point data is undefined until written.
module touch_gesture_recognizer_core #(
  parameter int MAX_POINTS = tgr_pkg::MaxPointsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tgr_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tgr_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import tgr_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tap_max_ms <= TapMaxReset;
      cfg.move_limit <= MoveLimitReset;
      cfg.double_tap_ms <= DoubleTapReset;
      cfg.long_press_ms <= LongPressReset;
      cfg.swipe_min_dist <= SwipeMinReset;
      cfg.swipe_max_ms <= SwipeMaxReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegTapMax:    cfg.tap_max_ms <= cfg_data;
        RegMoveLimit: cfg.move_limit <= cfg_data[11:0];
        RegDoubleTap: cfg.double_tap_ms <= cfg_data;
        RegLongPress: cfg.long_press_ms <= cfg_data;
        RegSwipeMin:  cfg.swipe_min_dist <= cfg_data[11:0];
        RegSwipeMax:  cfg.swipe_max_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  tgr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  tgr_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk(clk), .rst(rst), .in_data(in_data), .cfg(cfg), .cmd(cmd),
    .out_hold(out_valid && out_stall), .sts(sts), .out_data(out_data)
  );

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> in_stall)
    else $error("input accepted during close");
  a_gest: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.gesture <= GestLong)
    else $error("bad gesture code");
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import tgr_pkg::*;

  localparam int MaxPts = MaxPointsDefault;
  localparam int WatchLimit = 4000;
  localparam int DrainCycles = 30;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  touch_gesture_recognizer_core i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow registers.
  logic [15:0] tap_max, dbl_win, press_ms, swipe_max;
  logic [11:0] move_lim, swipe_min;

  // Shadow gesture state.
  logic [2:0] prev_cnt;
  logic [31:0] tap_t, press_begin;
  logic [11:0] tap_px, tap_py;
  int unsigned pidx;
  logic [15:0] acc_x, acc_y;
  logic [11:0] f_x, f_y, f_bx, f_by, s_x, s_y;
  logic [31:0] f_beg, f_fin;
  logic f_act, f_was;

  in_item_t pending_pts[$];
  out_item_t gestures_due[$];
  int mismatches;
  int fail_count;
  int idle_cycles;
  logic [31:0] clock_ms;

  function automatic logic [31:0] int_sqrt(logic [31:0] v);
    logic [31:0] r, b;
    r = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] abs_diff(logic [31:0] a, logic [31:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic predict_gesture(input in_item_t it);
    out_item_t o;
    int dx, dy, ax, ay;
    logic [31:0] d2, dur, lim2, now;
    logic [2:0] cnt;
    now = it.now_ms;
    cnt = it.active_count;
    if (pidx < MaxPts) begin
      if (pidx == 0) begin
        f_x = it.pt_x; f_y = it.pt_y; f_bx = it.begin_x; f_by = it.begin_y;
        f_beg = it.touch_begin_ms; f_fin = it.touch_finish_ms;
        f_act = it.pt_active; f_was = it.pt_was_active;
      end else if (pidx == 1) begin
        s_x = it.pt_x; s_y = it.pt_y;
      end
      if (pidx < prev_cnt) begin
        acc_x = acc_x + it.pt_x;
        acc_y = acc_y + it.pt_y;
      end
      pidx++;
    end
    if (!it.last_point) return;
    o = '0;
    o.gesture = GestNone;
    o.fingers = cnt;
    o.stamp_ms = now;
    dx = int'(f_x) - int'(f_bx);
    dy = int'(f_y) - int'(f_by);
    d2 = dx * dx + dy * dy;
    lim2 = 32'(move_lim) * 32'(move_lim);
    if (prev_cnt > 0 && cnt == 0) begin
      if (prev_cnt == 1) begin
        o.fingers = 1; o.pos_x = f_x; o.pos_y = f_y;
        if (f_was) begin
          dur = f_fin - f_beg;
          if (d2 <= lim2 && dur <= 32'(tap_max)) begin
            if (now - tap_t < 32'(dbl_win) && abs_diff(f_x, tap_px) < 32'(move_lim) &&
                abs_diff(f_y, tap_py) < 32'(move_lim)) begin
              o.gesture = GestDouble; o.amount = 2; tap_t = 0;
            end else begin
              o.gesture = GestTap; o.amount = 1;
              tap_t = now; tap_px = f_x; tap_py = f_y;
            end
          end else if (d2 > 32'(swipe_min) * 32'(swipe_min) &&
                       dur < 32'(swipe_max)) begin
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            if (ax > ay) o.gesture = dx > 0 ? GestRight : GestLeft;
            else o.gesture = dy > 0 ? GestDown : GestUp;
            o.amount = int_sqrt(d2);
          end
        end
      end else if (prev_cnt == 2) begin
        o.gesture = GestTwo; o.fingers = 2; o.amount = 2;
        o.pos_x = 12'((13'(f_x) + 13'(s_x)) >> 1);
        o.pos_y = 12'((13'(f_y) + 13'(s_y)) >> 1);
      end else begin
        o.gesture = GestMulti; o.fingers = prev_cnt; o.amount = prev_cnt;
        o.pos_x = 12'(acc_x / prev_cnt);
        o.pos_y = 12'(acc_y / prev_cnt);
      end
    end
    if (cnt == 1 && prev_cnt == 1 && f_act) begin
      dur = now - f_beg;
      if (dur > 32'(press_ms) && d2 <= lim2 && f_beg != press_begin) begin
        o.gesture = GestLong; o.pos_x = f_x; o.pos_y = f_y;
        o.amount = dur; o.fingers = 1;
        press_begin = f_beg;
      end
    end
    prev_cnt = cnt;
    pidx = 0; acc_x = 0; acc_y = 0;
    gestures_due.push_back(o);
  endtask

  // Driver: bursts of requests separated by random gaps.
  int burst_left, gap_left;
  always @(posedge clk) begin : drive_points
    logic took;
    took = in_valid && !in_stall;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (took) predict_gesture(in_data);
      if (!in_valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_pts.size() > 0) begin
          in_data <= pending_pts.pop_front();
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result and stalls on its own pattern.
  int stall_phase;
  always @(posedge clk) begin : watch_results
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_phase = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (gestures_due.size() == 0) begin
          fail_count++;
          if (mismatches < 10) $display("unexpected result %p", out_data);
          mismatches++;
        end else begin
          want = gestures_due.pop_front();
          if (out_data.gesture !== want.gesture || out_data.pos_x !== want.pos_x ||
              out_data.pos_y !== want.pos_y || out_data.fingers !== want.fingers ||
              out_data.stamp_ms !== want.stamp_ms || out_data.amount !== want.amount) begin
            fail_count++;
            if (mismatches < 10)
              $display("mismatch: expected %p got %p", want, out_data);
            mismatches++;
          end
        end
      end
      stall_phase = (stall_phase + 1) % 600;
      if (stall_phase < 200) out_stall <= 1'b0;
      else if (stall_phase < 400) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 1) == 0);
    end
  end

  // A run of cycles with no request moving on either side means the block hung.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      RegTapMax: tap_max = val;
      RegMoveLimit: move_lim = val[11:0];
      RegDoubleTap: dbl_win = val;
      RegLongPress: press_ms = val;
      RegSwipeMin: swipe_min = val[11:0];
      RegSwipeMax: swipe_max = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(input logic [15:0] tm, input logic [11:0] ml, input logic [15:0] dt,
                         input logic [15:0] lp, input logic [11:0] sm, input logic [15:0] sx);
    write_reg(RegTapMax, tm);
    write_reg(RegMoveLimit, {4'd0, ml});
    write_reg(RegDoubleTap, dt);
    write_reg(RegLongPress, lp);
    write_reg(RegSwipeMin, {4'd0, sm});
    write_reg(RegSwipeMax, sx);
  endtask

  task automatic wait_drained();
    while (pending_pts.size() != 0 || in_valid || gestures_due.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic in_item_t rand_pt();
    in_item_t p;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    p.last_point = 1'b0;
    return p;
  endfunction

  // One frame: the first point is given, the rest are random; the last closes it.
  task automatic add_frame(input logic [2:0] cnt, input int npts, input logic [31:0] now,
                           input logic [11:0] x, input logic [11:0] y,
                           input logic [11:0] bx, input logic [11:0] by,
                           input logic [31:0] beg, input logic [31:0] fin,
                           input logic act, input logic was);
    in_item_t p;
    for (int i = 0; i < npts; i++) begin
      p = rand_pt();
      if (i == 0) begin
        p.pt_x = x; p.pt_y = y; p.begin_x = bx; p.begin_y = by;
        p.touch_begin_ms = beg; p.touch_finish_ms = fin;
        p.pt_active = act; p.pt_was_active = was;
      end
      if (i == npts - 1) begin
        p.last_point = 1'b1;
        p.now_ms = now;
        p.active_count = cnt;
      end
      pending_pts.push_back(p);
    end
  endtask

  // A one-finger touch: press, optional holds, then lift.
  task automatic one_finger(input int hold_ms, input int move, input int holds);
    logic [31:0] t0;
    logic [11:0] bx, by, x, y;
    t0 = clock_ms;
    bx = $urandom; by = $urandom;
    x = bx + 12'($urandom_range(0, 2 * move) - move);
    y = by + 12'($urandom_range(0, 2 * move) - move);
    add_frame(1, $urandom_range(1, 2), t0, bx, by, bx, by, t0, 0, 1, 0);
    for (int i = 0; i < holds; i++) begin
      clock_ms += $urandom_range(1, 2 * hold_ms / (holds + 1) + 1);
      add_frame(1, $urandom_range(1, 3), clock_ms, x, y, bx, by, t0, 0, 1, 1);
    end
    clock_ms = t0 + hold_ms;
    add_frame(0, $urandom_range(1, 2), clock_ms + $urandom_range(0, 3), x, y, bx, by, t0,
              clock_ms, 0, ($urandom_range(0, 7) != 0));
    clock_ms += $urandom_range(1, 300);
  endtask

  task automatic many_fingers(input int k);
    add_frame(3'(k), $urandom_range(1, 7), clock_ms, $urandom, $urandom, $urandom,
              $urandom, clock_ms, 0, 1, 0);
    clock_ms += $urandom_range(1, 200);
    add_frame(0, $urandom_range(1, 7), clock_ms, $urandom, $urandom, $urandom,
              $urandom, clock_ms, clock_ms, 0, 1);
    clock_ms += $urandom_range(1, 200);
  endtask

  task automatic random_touches(input int n_items);
    int k;
    in_item_t p;
    while (pending_pts.size() < n_items) begin
      case ($urandom_range(0, 9))
        0, 1: one_finger($urandom_range(0, 400), $urandom_range(0, 25), 0);
        2: one_finger($urandom_range(0, 2000), $urandom_range(0, 30), $urandom_range(1, 4));
        3, 4: one_finger($urandom_range(0, 700), $urandom_range(0, 2047), 0);
        5: begin
          one_finger($urandom_range(0, 200), $urandom_range(0, 10), 0);
          clock_ms -= $urandom_range(0, 250);
          one_finger($urandom_range(0, 200), $urandom_range(0, 10), 0);
        end
        6, 7: many_fingers($urandom_range(2, 7));
        default: begin
          k = $urandom_range(1, 8);
          for (int i = 0; i < k; i++) begin
            p = rand_pt();
            p.last_point = (i == k - 1);
            pending_pts.push_back(p);
          end
        end
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = RegTapMax;
    cfg_data = '0;
    mismatches = 0;
    fail_count = 0;
    idle_cycles = 0;
    clock_ms = 32'd1000;
    tap_max = TapMaxReset; move_lim = MoveLimitReset; dbl_win = DoubleTapReset;
    press_ms = LongPressReset; swipe_min = SwipeMinReset; swipe_max = SwipeMaxReset;
    prev_cnt = 0; tap_t = 0; tap_px = 0; tap_py = 0; press_begin = 0;
    pidx = 0; acc_x = 0; acc_y = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: two-finger midpoint first so the second point store is written.
    add_frame(2, 2, 100, 12'hFFF, 12'hFFF, 0, 0, 90, 0, 1, 0);
    add_frame(0, 2, 110, 12'hFFF, 12'hFFF, 0, 0, 90, 110, 0, 1);
    // Tap, then a double tap close to it.
    add_frame(1, 1, 200, 500, 500, 500, 500, 200, 0, 1, 0);
    add_frame(0, 1, 250, 505, 503, 500, 500, 200, 250, 0, 1);
    add_frame(1, 1, 300, 501, 501, 501, 501, 300, 0, 1, 0);
    add_frame(0, 1, 350, 501, 501, 501, 501, 300, 350, 0, 1);
    // A lift with no touch before it (no gesture), then swipes left, down and up.
    add_frame(0, 1, 400, 900, 100, 100, 100, 380, 400, 0, 1);
    add_frame(1, 1, 410, 0, 0, 0, 0, 410, 0, 1, 0);
    add_frame(0, 1, 420, 0, 100, 800, 100, 410, 420, 0, 1);
    add_frame(1, 1, 430, 0, 0, 0, 0, 430, 0, 1, 0);
    add_frame(0, 1, 440, 100, 4095, 100, 0, 430, 440, 0, 1);
    add_frame(1, 1, 450, 0, 0, 0, 0, 450, 0, 1, 0);
    add_frame(0, 1, 460, 100, 0, 100, 4095, 450, 460, 0, 1);
    // Long press, reported once, with time wrapping around zero.
    add_frame(1, 1, 32'hFFFF_FF00, 7, 7, 7, 7, 32'hFFFF_FF00, 0, 1, 0);
    add_frame(1, 1, 32'd1000, 7, 7, 7, 7, 32'hFFFF_FF00, 0, 1, 1);
    add_frame(1, 1, 32'd2000, 7, 7, 7, 7, 32'hFFFF_FF00, 0, 1, 1);
    // Five-finger centroid with excess points, then a count above the maximum.
    add_frame(5, 5, 3000, 4095, 4095, 0, 0, 3000, 0, 1, 0);
    add_frame(0, 7, 3010, 4095, 4095, 0, 0, 3000, 3010, 0, 1);
    add_frame(7, 1, 3020, 1, 1, 1, 1, 3020, 0, 1, 0);
    add_frame(0, 3, 3030, 1, 1, 1, 1, 3020, 3030, 0, 1);
    wait_drained();

    clock_ms = 5000;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: ;
        1: set_all(0, 0, 0, 0, 0, 0);
        2: set_all(16'hFFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 16'hFFFF);
        3: set_all(TapMaxReset, MoveLimitReset, DoubleTapReset, LongPressReset,
                   SwipeMinReset, SwipeMaxReset);
        default: set_all($urandom_range(0, 800), $urandom_range(0, 60),
                         $urandom_range(0, 1000), $urandom_range(0, 2000),
                         $urandom_range(0, 100), $urandom_range(0, 1000));
      endcase
      random_touches(215);
      if (ph == 4) clock_ms = 32'hFFFF_F000;
      wait_drained();
    end

    if (fail_count == 0 && gestures_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* touch_gesture_recognizer_core.f */
sv/tgr_pkg.sv
sv/tgr_ctrl.sv
sv/tgr_dp.sv
sv/touch_gesture_recognizer_core.sv
tb/testbench.sv
